// ===== sv/scf_pkg.sv =====
// ----------------------------------------------------------------------------
// scf_pkg: shared types and constants of the PNG scanline filter
// Line and pixel limits, filter and register codes, position record.
// ----------------------------------------------------------------------------
package scf_pkg;

    localparam int MAX_LINE        = 4096;
    localparam int LINE_AW         = $clog2(MAX_LINE);
    localparam int LEN_W           = LINE_AW + 1;
    localparam int MAX_PIXEL_BYTES = 8;
    localparam int PIX_IW          = $clog2(MAX_PIXEL_BYTES);
    localparam int PIX_W           = 4;
    localparam int BYTE_W          = 8;
    localparam int APB_AW          = 4;
    localparam int APB_DW          = 32;

    typedef enum logic [2:0] {
        FT_NONE  = 3'd0,
        FT_SUB   = 3'd1,
        FT_UP    = 3'd2,
        FT_AVG   = 3'd3,
        FT_PAETH = 3'd4
    } filter_t;

    typedef enum logic [1:0] {
        REG_DIRECTION   = 2'd0,
        REG_LINE_BYTES  = 2'd1,
        REG_PIXEL_BYTES = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [LINE_AW-1:0] column;
        logic               first_row;
        logic               has_left;
        logic               line_end;
        logic               start;
        logic [PIX_IW-1:0]  pix_idx;
    } pos_t;

endpackage

// ===== sv/scf_ram.sv =====
// ----------------------------------------------------------------------------
// scf_ram: generic single-port-write, registered-read RAM
// One write and one read port; read data updates only on read enable.
// ----------------------------------------------------------------------------
module scf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/scf_position.sv =====
// ----------------------------------------------------------------------------
// scf_position: scanline position tracker
// Keeps column and first-row state; classifies each accepted byte.
// ----------------------------------------------------------------------------
module scf_position
    import scf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic              image_start,
    input  logic [LEN_W-1:0]  line_bytes,
    input  logic [PIX_W-1:0]  pixel_bytes,
    output pos_t              pos
);

    logic [LINE_AW-1:0] column_reg, column_next;
    logic               first_row_reg, first_row_next;
    logic [LEN_W-1:0]   len;
    logic [PIX_W-1:0]   bpp;
    logic [LEN_W-1:0]   col_start;
    logic [LEN_W-1:0]   col_clamped;
    logic [LEN_W-1:0]   col_inc;

    always_comb begin
        priority if (line_bytes == '0) begin
            len = LEN_W'(1);
        end else if (line_bytes > LEN_W'(MAX_LINE)) begin
            len = LEN_W'(MAX_LINE);
        end else begin
            len = line_bytes;
        end
        priority if (pixel_bytes == '0) begin
            bpp = PIX_W'(1);
        end else if (pixel_bytes > PIX_W'(MAX_PIXEL_BYTES)) begin
            bpp = PIX_W'(MAX_PIXEL_BYTES);
        end else begin
            bpp = pixel_bytes;
        end
    end

    always_comb begin
        col_start   = image_start ? '0 : {1'b0, column_reg};
        col_clamped = (col_start >= len) ? (len - LEN_W'(1)) : col_start;
        col_inc     = col_clamped + LEN_W'(1);

        pos.column    = col_clamped[LINE_AW-1:0];
        pos.first_row = image_start | first_row_reg;
        pos.has_left  = col_clamped >= LEN_W'(bpp);
        pos.line_end  = col_inc >= len;
        pos.start     = image_start;
        pos.pix_idx   = PIX_IW'(bpp - PIX_W'(1));
    end

    always_comb begin
        column_next    = column_reg;
        first_row_next = first_row_reg;
        if (accept) begin
            column_next    = pos.line_end ? '0 : col_inc[LINE_AW-1:0];
            first_row_next = pos.line_end ? 1'b0 : pos.first_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg    <= '0;
            first_row_reg <= 1'b1;
        end else begin
            column_reg    <= column_next;
            first_row_reg <= first_row_next;
        end
    end

endmodule

// ===== sv/scf_predict.sv =====
// ----------------------------------------------------------------------------
// scf_predict: PNG predictor and filter/unfilter arithmetic
// None, Sub, Up, Average and Paeth; result and row byte to keep.
// ----------------------------------------------------------------------------
module scf_predict
    import scf_pkg::*;
(
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [2:0]        filter_type,
    input  logic              direction,
    input  logic [BYTE_W-1:0] a,
    input  logic [BYTE_W-1:0] b,
    input  logic [BYTE_W-1:0] c,
    output logic [BYTE_W-1:0] res,
    output logic [BYTE_W-1:0] keep,
    output logic              bad
);

    logic signed [BYTE_W+2:0] da, db, dc;
    logic signed [BYTE_W+2:0] ea, eb, ec;
    logic        [BYTE_W+1:0] pa, pb, pc;
    logic        [BYTE_W-1:0] paeth;
    logic        [BYTE_W:0]   avg_sum;
    logic        [BYTE_W-1:0] pred;

    always_comb begin
        da = signed'({3'b000, a});
        db = signed'({3'b000, b});
        dc = signed'({3'b000, c});
        ea = db - dc;
        eb = da - dc;
        ec = da + db - dc - dc;
        pa = (BYTE_W+2)'(ea[BYTE_W+2] ? -ea : ea);
        pb = (BYTE_W+2)'(eb[BYTE_W+2] ? -eb : eb);
        pc = (BYTE_W+2)'(ec[BYTE_W+2] ? -ec : ec);
        priority if (pa <= pb && pa <= pc) begin
            paeth = a;
        end else if (pb <= pc) begin
            paeth = b;
        end else begin
            paeth = c;
        end
    end

    always_comb begin
        avg_sum = {1'b0, a} + {1'b0, b};
        bad     = 1'b0;
        unique case (filter_t'(filter_type))
            FT_NONE:  pred = '0;
            FT_SUB:   pred = a;
            FT_UP:    pred = b;
            FT_AVG:   pred = avg_sum[BYTE_W:1];
            FT_PAETH: pred = paeth;
            default: begin
                pred = '0;
                bad  = 1'b1;
            end
        endcase
    end

    always_comb begin
        priority if (bad) begin
            res  = data_byte;
            keep = data_byte;
        end else if (direction) begin
            res  = data_byte + pred;
            keep = res;
        end else begin
            res  = data_byte - pred;
            keep = data_byte;
        end
    end

endmodule

// ===== sv/png_scanline_filter.sv =====
// ----------------------------------------------------------------------------
// png_scanline_filter: streaming PNG scanline filter / unfilter
// Byte-wide PNG predictor with APB configuration and row-above RAM.
// ----------------------------------------------------------------------------
// Takes one byte per clock while the output is not stalled and returns one
// result per byte, in order, through the compute stage and the output register.
// The rate is set by the compute stage: the row-above byte comes from a 4096 x 8
// RAM read at acceptance, and the left neighbor is the kept byte one pixel back,
// held in history registers, so the predictor and add/subtract are combinational. The row
// RAM needs no clearing pass; bytes of the row above are valid once written.
// Registers: 0x0 direction, 0x4 line_bytes, 0x8 pixel_bytes; write only idle.
// ----------------------------------------------------------------------------
module png_scanline_filter
    import scf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_data_byte,
    input  logic [2:0]        s_filter_type,
    input  logic              s_image_start,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_out_byte,
    output logic              m_line_end,
    output logic              m_bad_type
);

    logic              direction_reg;
    logic [LEN_W-1:0]  line_bytes_reg;
    logic [PIX_W-1:0]  pixel_bytes_reg;
    logic              cfg_write;
    reg_idx_t          cfg_idx;

    logic              s_accept;
    pos_t              pos;

    logic              s1_valid_reg, s1_valid_next;
    logic [BYTE_W-1:0] s1_data_reg;
    logic [2:0]        s1_type_reg;
    pos_t              s1_pos_reg;
    logic              s1_leave;
    logic              byp_valid_reg;
    logic [BYTE_W-1:0] byp_byte_reg;

    logic [BYTE_W-1:0] left_hist_reg   [MAX_PIXEL_BYTES];
    logic [BYTE_W-1:0] upleft_hist_reg [MAX_PIXEL_BYTES];

    logic [BYTE_W-1:0] ram_rdata;
    logic [BYTE_W-1:0] a, b, c;
    logic [BYTE_W-1:0] res, keep;
    logic              bad;

    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] m_out_byte_reg;
    logic              m_line_end_reg;
    logic              m_bad_type_reg;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_idx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg   <= 1'b0;
            line_bytes_reg  <= LEN_W'(1);
            pixel_bytes_reg <= PIX_W'(1);
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_DIRECTION:   direction_reg   <= pwdata[0];
                REG_LINE_BYTES:  line_bytes_reg  <= pwdata[LEN_W-1:0];
                REG_PIXEL_BYTES: pixel_bytes_reg <= pwdata[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_DIRECTION:   prdata = APB_DW'(direction_reg);
            REG_LINE_BYTES:  prdata = APB_DW'(line_bytes_reg);
            REG_PIXEL_BYTES: prdata = APB_DW'(pixel_bytes_reg);
            default:         prdata = '0;
        endcase
    end

    // request handshakes
    assign s1_leave = s1_valid_reg & (~m_valid_reg | m_ready);
    assign s_ready  = ~s1_valid_reg | s1_leave;
    assign s_accept = s_valid & s_ready;

    scf_position u_position (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_accept),
        .image_start (s_image_start),
        .line_bytes  (line_bytes_reg),
        .pixel_bytes (pixel_bytes_reg),
        .pos         (pos)
    );

    scf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_LINE)
    ) u_above_ram (
        .aclk  (aclk),
        .we    (s1_leave),
        .waddr (s1_pos_reg.column),
        .wdata (keep),
        .re    (s_accept),
        .raddr (pos.column),
        .rdata (ram_rdata)
    );

    // compute stage
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_leave) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            if (s_accept) begin
                byp_valid_reg <= s1_leave && (s1_pos_reg.column == pos.column);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_data_reg  <= s_data_byte;
            s1_type_reg  <= s_filter_type;
            s1_pos_reg   <= pos;
            byp_byte_reg <= keep;
        end
    end

    always_comb begin
        if (s1_pos_reg.first_row) begin
            b = '0;
        end else if (byp_valid_reg) begin
            b = byp_byte_reg;
        end else begin
            b = ram_rdata;
        end
        a = s1_pos_reg.has_left ? left_hist_reg[s1_pos_reg.pix_idx]   : '0;
        c = s1_pos_reg.has_left ? upleft_hist_reg[s1_pos_reg.pix_idx] : '0;
    end

    scf_predict u_predict (
        .data_byte   (s1_data_reg),
        .filter_type (s1_type_reg),
        .direction   (direction_reg),
        .a           (a),
        .b           (b),
        .c           (c),
        .res         (res),
        .keep        (keep),
        .bad         (bad)
    );

    // pixel history, cleared at image start and line end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                left_hist_reg[i]   <= '0;
                upleft_hist_reg[i] <= '0;
            end
        end else if (s1_leave) begin
            if (s1_pos_reg.line_end) begin
                for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                    left_hist_reg[i]   <= '0;
                    upleft_hist_reg[i] <= '0;
                end
            end else begin
                for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
                    left_hist_reg[i]   <= s1_pos_reg.start ? '0 : left_hist_reg[i-1];
                    upleft_hist_reg[i] <= s1_pos_reg.start ? '0 : upleft_hist_reg[i-1];
                end
                left_hist_reg[0]   <= keep;
                upleft_hist_reg[0] <= b;
            end
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_leave) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_leave) begin
            m_out_byte_reg <= res;
            m_line_end_reg <= s1_pos_reg.line_end;
            m_bad_type_reg <= bad;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;
    assign m_line_end = m_line_end_reg;
    assign m_bad_type = m_bad_type_reg;

`ifndef NO_ASSERTIONS
    a_bad_passthru: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && bad |-> res == s1_data_reg && keep == s1_data_reg)
        else $error("invalid filter type did not pass byte through");

    a_line_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && pos.line_end |=> u_position.column_reg == '0)
        else $error("column did not wrap at line end");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_leave |=> s1_valid_reg && $stable(s1_data_reg)
            && $stable(s1_pos_reg))
        else $error("compute stage lost a stalled byte");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte)
            && $stable(m_line_end) && $stable(m_bad_type))
        else $error("result changed while stalled");

    a_first_row_b: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_pos_reg.first_row |-> b == '0)
        else $error("row above used on first line");
`endif

endmodule

// ===== bench/scanline_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scanline_checker: result predictor and comparator for png_scanline_filter
// Mirrors register writes seen on the APB port, predicts the byte, line end
// and bad-type flag of every accepted request and compares each accepted
// result, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module scanline_checker
    import scf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [BYTE_W-1:0] s_data_byte,
    input  logic [2:0]        s_filter_type,
    input  logic              s_image_start,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [BYTE_W-1:0] m_out_byte,
    input  logic              m_line_end,
    input  logic              m_bad_type,
    output int                fail_count,
    output int                pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              line_end;
        logic              bad_type;
    } scan_result_t;

    logic                  cfg_unfilter;
    logic [LEN_W-1:0]      cfg_line_bytes;
    logic [PIX_W-1:0]      cfg_pixel_bytes;

    logic [BYTE_W-1:0]     row_above    [MAX_LINE];
    logic [BYTE_W-1:0]     left_bytes   [MAX_PIXEL_BYTES];
    logic [BYTE_W-1:0]     upleft_bytes [MAX_PIXEL_BYTES];
    int                    col;
    logic                  on_first_row;

    scan_result_t          expected_bytes [$];
    int                    errors;

    function automatic int abs_dist(input int x, input int y);
        return (x > y) ? x - y : y - x;
    endfunction

    function automatic scan_result_t predict_byte(input logic [BYTE_W-1:0] d,
                                                  input logic [2:0] ft,
                                                  input logic st);
        int                len;
        int                bpp;
        int                a;
        int                b;
        int                c;
        int                pred;
        int                pa;
        int                pb;
        int                pc;
        logic              bad;
        logic [BYTE_W-1:0] res;
        logic [BYTE_W-1:0] keep;
        scan_result_t      r;

        len  = (cfg_line_bytes == 0) ? 1 : int'(cfg_line_bytes);
        if (len > MAX_LINE) len = MAX_LINE;
        bpp  = (cfg_pixel_bytes == 0) ? 1 : int'(cfg_pixel_bytes);
        if (bpp > MAX_PIXEL_BYTES) bpp = MAX_PIXEL_BYTES;
        a    = 0;
        b    = 0;
        c    = 0;
        pred = 0;
        bad  = 1'b0;

        if (st) begin
            col          = 0;
            on_first_row = 1'b1;
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                left_bytes[i]   = '0;
                upleft_bytes[i] = '0;
            end
        end
        if (col >= len) col = len - 1;

        if (!on_first_row) b = row_above[col];
        if (col >= bpp) begin
            a = left_bytes[bpp-1];
            c = upleft_bytes[bpp-1];
        end

        case (ft)
            FT_NONE:  pred = 0;
            FT_SUB:   pred = a;
            FT_UP:    pred = b;
            FT_AVG:   pred = (a + b) >> 1;
            FT_PAETH: begin
                pa = abs_dist(b, c);
                pb = abs_dist(a, c);
                pc = abs_dist(a + b, c + c);
                if (pa <= pb && pa <= pc) pred = a;
                else if (pb <= pc)        pred = b;
                else                      pred = c;
            end
            default:  bad = 1'b1;
        endcase

        if (bad) begin
            res  = d;
            keep = d;
        end else if (cfg_unfilter) begin
            res  = 8'(d + pred);
            keep = res;
        end else begin
            res  = 8'(d - pred);
            keep = d;
        end

        for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
            left_bytes[i]   = left_bytes[i-1];
            upleft_bytes[i] = upleft_bytes[i-1];
        end
        left_bytes[0]   = keep;
        upleft_bytes[0] = 8'(b);
        row_above[col]  = keep;

        r.out_byte = res;
        r.bad_type = bad;
        r.line_end = (col + 1 >= len);
        if (r.line_end) begin
            col          = 0;
            on_first_row = 1'b0;
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                left_bytes[i]   = '0;
                upleft_bytes[i] = '0;
            end
        end else begin
            col++;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        scan_result_t want;
        if (!aresetn) begin
            cfg_unfilter    = 1'b0;
            cfg_line_bytes  = LEN_W'(1);
            cfg_pixel_bytes = PIX_W'(1);
            col             = 0;
            on_first_row    = 1'b1;
            errors          = 0;
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                left_bytes[i]   = '0;
                upleft_bytes[i] = '0;
            end
            expected_bytes.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_DIRECTION:   cfg_unfilter    = pwdata[0];
                    REG_LINE_BYTES:  cfg_line_bytes  = pwdata[LEN_W-1:0];
                    REG_PIXEL_BYTES: cfg_pixel_bytes = pwdata[PIX_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0h/%0b/%0b",
                             $time, m_out_byte, m_line_end, m_bad_type);
                    errors++;
                end else begin
                    want = expected_bytes.pop_front();
                    check_field("out_byte", want.out_byte, m_out_byte);
                    check_field("line_end", want.line_end, m_line_end);
                    check_field("bad_type", want.bad_type, m_bad_type);
                end
            end
            if (s_valid && s_ready)
                expected_bytes.push_back(predict_byte(s_data_byte, s_filter_type,
                                                      s_image_start));
        end
        fail_count <= errors;
        pending    <= expected_bytes.size();
    end

endmodule

// ===== bench/tb_png_scanline_filter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_png_scanline_filter: stimulus and verdict for png_scanline_filter
// Directed corner requests, then phases of random image streams under
// several register settings, with bursty requests and a stalling receiver.
// Checking is done by scanline_checker.
// ----------------------------------------------------------------------------
module tb_png_scanline_filter;
    import scf_pkg::*;

    localparam logic [2:0] FT_FIRST_BAD = 3'd5;
    localparam logic [2:0] FT_LAST_BAD  = 3'd7;
    localparam int         IDLE_LIMIT   = 5000;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [APB_AW-1:0] paddr         = '0;
    logic [APB_DW-1:0] pwdata        = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [BYTE_W-1:0] s_data_byte   = '0;
    logic [2:0]        s_filter_type = '0;
    logic              s_image_start = 1'b0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [BYTE_W-1:0] m_out_byte;
    logic              m_line_end;
    logic              m_bad_type;

    int                fail_count;
    int                pending;

    int                burst_left    = 0;
    int                stim_col      = 0;
    int                cur_len       = 1;
    logic              need_start    = 1'b0;
    logic [2:0]        line_kind     = FT_NONE;
    int                stall_mode    = 0;
    int                stall_left    = 0;
    int                idle_cycles   = 0;

    always #1 aclk = ~aclk;

    png_scanline_filter dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_filter_type (s_filter_type),
        .s_image_start (s_image_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_line_end    (m_line_end),
        .m_bad_type    (m_bad_type)
    );

    scanline_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_filter_type (s_filter_type),
        .s_image_start (s_image_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_line_end    (m_line_end),
        .m_bad_type    (m_bad_type),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // receiver backpressure
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (stall_left % 7) > 2;
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic wait_idle();
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    // a longer line would read row bytes never written, so growth restarts the image
    task automatic write_config(input logic dir, input int len, input int pix);
        int eff;
        wait_idle();
        apb_write(REG_DIRECTION, APB_DW'(dir));
        apb_write(REG_LINE_BYTES, APB_DW'(len));
        apb_write(REG_PIXEL_BYTES, APB_DW'(pix));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        eff = (len == 0) ? 1 : (len > MAX_LINE) ? MAX_LINE : len;
        if (eff > cur_len) need_start = 1'b1;
        cur_len = eff;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] d, input logic [2:0] ft,
                             input logic st);
        logic start;
        start      = st | need_start;
        need_start = 1'b0;
        s_valid       <= 1'b1;
        s_data_byte   <= d;
        s_filter_type <= ft;
        s_image_start <= start;
        do @(posedge aclk); while (!(s_valid && s_ready));
        if (start) stim_col = 0;
        if (stim_col >= cur_len) stim_col = cur_len - 1;
        stim_col = (stim_col + 1 >= cur_len) ? 0 : stim_col + 1;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(0, 60);
        end
    endtask

    task automatic send_random(input int n);
        logic [BYTE_W-1:0] d;
        logic [2:0]        ft;
        for (int i = 0; i < n; i++) begin
            if (stim_col == 0)
                line_kind = ($urandom_range(0, 9) == 0) ?
                            3'($urandom_range(FT_FIRST_BAD, FT_LAST_BAD)) :
                            3'($urandom_range(FT_NONE, FT_PAETH));
            ft = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : line_kind;
            if ($urandom_range(0, 9) == 0)
                d = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                d = 8'($urandom);
            send_byte(d, ft, $urandom_range(0, 249) == 0);
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        static logic ph_dir [8] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        static int   ph_len [8] = '{1, 1, 5, 16, 37, 8, 4096, 12};
        static int   ph_pix [8] = '{1, 8, 3, 4, 2, 8, 8, 5};
        static int   ph_num [8] = '{60, 60, 90, 90, 100, 90, 150, 90};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // filter mode: extremes, every type, invalid types
        write_config(1'b0, 4, 1);
        send_byte(8'h00, FT_NONE, 1'b1);
        send_byte(8'hFF, FT_SUB, 1'b0);
        send_byte(8'h80, FT_UP, 1'b0);
        send_byte(8'h7F, FT_AVG, 1'b0);
        send_byte(8'h12, FT_PAETH, 1'b0);
        send_byte(8'hFF, FT_FIRST_BAD, 1'b0);
        send_byte(8'h01, FT_FIRST_BAD + 3'd1, 1'b0);
        send_byte(8'h55, FT_LAST_BAD, 1'b0);
        send_byte(8'hFF, FT_PAETH, 1'b0);
        send_byte(8'h00, FT_AVG, 1'b0);
        s_valid <= 1'b0;

        // reconstruct mode, two-byte pixels
        write_config(1'b1, 3, 2);
        send_byte(8'hFF, FT_SUB, 1'b1);
        send_byte(8'hFF, FT_SUB, 1'b0);
        send_byte(8'h01, FT_SUB, 1'b0);
        send_byte(8'hFF, FT_AVG, 1'b0);
        send_byte(8'h80, FT_PAETH, 1'b0);
        send_byte(8'hFF, FT_UP, 1'b0);
        s_valid <= 1'b0;

        // zero line and pixel sizes
        write_config(1'b0, 0, 0);
        send_byte(8'hAA, FT_SUB, 1'b0);
        send_byte(8'h55, FT_UP, 1'b0);
        s_valid <= 1'b0;

        // oversized registers, then a shrink mid-line
        write_config(1'b1, 8191, 15);
        send_byte(8'h10, FT_NONE, 1'b1);
        for (int i = 0; i < 6; i++)
            send_byte(8'hFF - 8'(i), (i % 2) ? FT_PAETH : FT_SUB, 1'b0);
        s_valid <= 1'b0;
        write_config(1'b0, 5, 1);
        send_byte(8'h33, FT_PAETH, 1'b0);
        send_byte(8'h44, FT_UP, 1'b0);
        s_valid <= 1'b0;

        for (int p = 0; p < 8; p++) begin
            write_config(ph_dir[p], ph_len[p], ph_pix[p]);
            send_random(ph_num[p]);
        end
        for (int p = 0; p < 6; p++) begin
            write_config(1'($urandom_range(0, 1)), $urandom_range(1, 40),
                         $urandom_range(1, 8));
            send_random(90);
        end

        do @(posedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/scf_pkg.sv
sv/scf_ram.sv
sv/scf_position.sv
sv/scf_predict.sv
sv/png_scanline_filter.sv
bench/scanline_checker.sv
bench/tb_png_scanline_filter.sv
